// ===== hw/rtl/nrd_pkg.sv =====
// Package for the non-restoring divider.
// Holds shared constants; used by the top level and the checker.
package nrd_pkg;

   // default operand width
   localparam int DEFAULT_WIDTH = 8;

endpackage

// ===== hw/rtl/nrd_cell.sv =====
// One non-restoring division step with its pipeline register.
// Depends on nrd_pkg; instantiated WIDTH times by non_restoring_divider.
module nrd_cell #(
   parameter int WIDTH = nrd_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   // upstream side
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [WIDTH+1:0] in_a,
   input  logic [WIDTH-1:0] in_q,
   input  logic [WIDTH-1:0] in_m,
   input  logic             in_dz,
   // downstream side
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH+1:0] out_a,
   output logic [WIDTH-1:0] out_q,
   output logic [WIDTH-1:0] out_m,
   output logic             out_dz
);

   logic             valid_ff, valid_in;
   logic [WIDTH+1:0] a_ff, a_in;
   logic [WIDTH-1:0] q_ff, q_in;
   logic [WIDTH-1:0] m_ff;
   logic             dz_ff;
   logic [WIDTH+1:0] a_shift;
   logic [WIDTH+1:0] m_ext;

   // hold while full and the next cell cannot take the request
   assign in_stall = valid_ff && out_stall;

   // shift A:Q left, then subtract or add the divisor by the sign of A
   always_comb begin
      a_shift = {in_a[WIDTH:0], in_q[WIDTH-1]};
      m_ext   = {2'b00, in_m};
      if (!in_a[WIDTH+1]) begin
         a_in = a_shift - m_ext;
      end else begin
         a_in = a_shift + m_ext;
      end
      q_in = {in_q[WIDTH-2:0], ~a_in[WIDTH+1]};
   end

   assign valid_in = in_stall ? valid_ff : in_valid;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         a_ff  <= a_in;
         q_ff  <= q_in;
         m_ff  <= in_m;
         dz_ff <= in_dz;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_q     = q_ff;
   assign out_m     = m_ff;
   assign out_dz    = dz_ff;

endmodule

// ===== hw/rtl/nrd_fix.sv =====
// Final remainder correction and response register of the divider.
// Depends on nrd_pkg; instantiated once by non_restoring_divider.
module nrd_fix #(
   parameter int WIDTH = nrd_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [WIDTH+1:0] in_a,
   input  logic [WIDTH-1:0] in_q,
   input  logic [WIDTH-1:0] in_m,
   input  logic             in_dz,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH-1:0] out_quotient,
   output logic [WIDTH-1:0] out_remainder,
   output logic             out_dz
);

   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] quot_ff, quot_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic             dz_ff;
   logic [WIDTH+1:0] a_fixed;

   assign in_stall = valid_ff && out_stall;

   // add the divisor back once if the remainder ended negative;
   // a zero divisor forces both fields to zero
   always_comb begin
      a_fixed = in_a[WIDTH+1] ? (in_a + {2'b00, in_m}) : in_a;
      if (in_dz) begin
         quot_in = '0;
         rem_in  = '0;
      end else begin
         quot_in = in_q;
         rem_in  = a_fixed[WIDTH-1:0];
      end
   end

   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         dz_ff   <= in_dz;
      end
   end

   assign out_valid     = valid_ff;
   assign out_quotient  = quot_ff;
   assign out_remainder = rem_ff;
   assign out_dz        = dz_ff;

endmodule

// ===== hw/rtl/non_restoring_divider.sv =====
// Top level of the pipelined unsigned non-restoring divider.
// Depends on nrd_pkg, nrd_cell and nrd_fix.
//
// Divides an unsigned WIDTH-bit dividend by an unsigned WIDTH-bit divisor
// and returns quotient and remainder; a zero divisor returns zeros with
// divide_by_zero set. The datapath is a chain of WIDTH step cells, one
// quotient bit per cell, followed by a correction and response register,
// so a request passes through each cell register, then the response register.
// One request is accepted every cycle when not stalled; each stage holds its
// request only while it is full and the stage after it is stalled, so empty
// slots close up and requests keep entering while a response waits to be taken.
module non_restoring_divider #(
   parameter int WIDTH = nrd_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_dividend,
   input  logic [WIDTH-1:0] req_divisor,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_quotient,
   output logic [WIDTH-1:0] rsp_remainder,
   output logic             rsp_divide_by_zero
);

   // links between neighboring cells; index 0 is the request port
   logic             valid_w [0:WIDTH];
   logic             stall_w [0:WIDTH];
   logic [WIDTH+1:0] a_w     [0:WIDTH];
   logic [WIDTH-1:0] q_w     [0:WIDTH];
   logic [WIDTH-1:0] m_w     [0:WIDTH];
   logic             dz_w    [0:WIDTH];

   // entry: partial remainder starts at zero
   assign valid_w[0] = req_valid;
   assign req_stall  = stall_w[0];
   assign a_w[0]     = '0;
   assign q_w[0]     = req_dividend;
   assign m_w[0]     = req_divisor;
   assign dz_w[0]    = (req_divisor == '0);

   // one step per cell
   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      nrd_cell #(.WIDTH(WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_stall  (stall_w[i]),
         .in_a      (a_w[i]),
         .in_q      (q_w[i]),
         .in_m      (m_w[i]),
         .in_dz     (dz_w[i]),
         .out_valid (valid_w[i+1]),
         .out_stall (stall_w[i+1]),
         .out_a     (a_w[i+1]),
         .out_q     (q_w[i+1]),
         .out_m     (m_w[i+1]),
         .out_dz    (dz_w[i+1])
      );
   end

   // correction and response register
   nrd_fix #(.WIDTH(WIDTH)) u_fix (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (valid_w[WIDTH]),
      .in_stall      (stall_w[WIDTH]),
      .in_a          (a_w[WIDTH]),
      .in_q          (q_w[WIDTH]),
      .in_m          (m_w[WIDTH]),
      .in_dz         (dz_w[WIDTH]),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_quotient  (rsp_quotient),
      .out_remainder (rsp_remainder),
      .out_dz        (rsp_divide_by_zero)
   );

endmodule

// ===== hw/rtl/nrd_checker.sv =====
// Port-level assertions for non_restoring_divider, with the bind that
// attaches them. Depends on nrd_pkg and non_restoring_divider.
module nrd_checker #(
   parameter int WIDTH = nrd_pkg::DEFAULT_WIDTH
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [WIDTH-1:0] req_dividend,
   input logic [WIDTH-1:0] req_divisor,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [WIDTH-1:0] rsp_quotient,
   input logic [WIDTH-1:0] rsp_remainder,
   input logic             rsp_divide_by_zero
);

   // request side only stalls when a response is backed up
   a_stall_src : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // divide by zero gives zero fields
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_quotient == '0 && rsp_remainder == '0))
      else $error("divide by zero response has nonzero fields");

   // pipeline is empty right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_quotient)
         && $stable(rsp_remainder) && $stable(rsp_divide_by_zero)))
      else $error("stalled response changed");

   // a stalled request holds
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_dividend)
         && $stable(req_divisor)))
      else $error("stalled request changed");

endmodule

bind non_restoring_divider nrd_checker #(.WIDTH(WIDTH)) u_nrd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_dividend       (req_dividend),
   .req_divisor        (req_divisor),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_quotient       (rsp_quotient),
   .rsp_remainder      (rsp_remainder),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);
